// ===== rtl/pta_pkg.sv =====
// Shared types and constants for the pressure-to-altitude interpolator.
// Holds the standard-atmosphere pressure table and the datapath widths.
// No dependencies; used by pta_div and the top level of the block.
package pta_pkg;

  // Datapath widths.
  localparam int PRES_W = 16;          // input pressure, Pa/4
  localparam int ALT_W = 15;           // output altitude, meters
  localparam int ENTRY_W = 15;         // one stored table entry
  localparam int DIV_W = 16;           // divisor: difference of two entries
  localparam int QUO_W = 11;           // interpolation offset is below 2048
  localparam int NUM_W = DIV_W + QUO_W; // rounded numerator of the divide

  // Altitude step between neighboring table entries.
  localparam int STEP_M = 2000;

  // Standard-atmosphere pressure at 0, 2000, ... 32000 m, in Pa/4.
  localparam int STORED_ENTRIES = 17;
  localparam int TBL_IW = 5;
  localparam logic [ENTRY_W-1:0] ATMOS_TABLE [STORED_ENTRIES] = '{
    15'd25325, 15'd19875, 15'd15415, 15'd11805,
    15'd8913,  15'd6625,  15'd4850,  15'd3543,  15'd2588,  15'd1891,
    15'd1382,  15'd1012,  15'd743,   15'd547,   15'd404,   15'd299,
    15'd222
  };

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/pta_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Parameterized in word width and depth; no package dependencies.
module pta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pta_div.sv =====
// Restoring divider for the interpolation step, one quotient bit per cycle.
// Depends on pta_pkg for widths and the status struct.
module pta_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pta_pkg::NUM_W-1:0]  dividend,
  input  logic [pta_pkg::DIV_W-1:0]  divisor,
  output pta_pkg::div_stat_t         stat,
  output logic [pta_pkg::QUO_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(pta_pkg::QUO_W);

  logic [pta_pkg::NUM_W-1:0] rem;
  logic [pta_pkg::NUM_W-1:0] dsh;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;
  logic                      ge;

  // The shifted divisor fits under the remainder: take this quotient bit.
  assign ge = (rem >= dsh);

  // Control: step counter and status flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(pta_pkg::QUO_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - CNT_W'(1);
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: remainder, shifted divisor and quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= pta_pkg::NUM_W'(divisor) << (pta_pkg::QUO_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= {quotient[pta_pkg::QUO_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/pressure_to_altitude_interp_core.sv =====
// Top level of the pressure-to-altitude interpolator: table search and output.
// Depends on pta_pkg, pta_ram (table store) and pta_div (interpolation divide).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  in      | request   | in_valid/in_stall  | pressure [15:0], Pa/4
//  out     | result    | out_valid/out_stall| altitude [14:0], meters
//
// After reset the table RAM is loaded from the package, one entry a cycle;
// in_stall stays high meanwhile. A request is searched one entry a cycle
// from acceptance, comparing k entries (1..17); when the pressure falls
// between two entries, interpolation adds a setup step and the bit-serial
// divide. No new request is taken until the last result has been handed to
// the output register. A finished result waits in the output register while
// the next request is taken; out_stall only holds the last step.
module pressure_to_altitude_interp_core #(
  parameter int TABLE_ENTRIES = 17
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pta_pkg::PRES_W-1:0] pressure,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pta_pkg::ALT_W-1:0]  altitude
);

  localparam int ENTRIES = (TABLE_ENTRIES > pta_pkg::STORED_ENTRIES) ?
                           pta_pkg::STORED_ENTRIES :
                           ((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
  localparam logic [pta_pkg::ALT_W-1:0] SAT_ALT =
    pta_pkg::ALT_W'((ENTRIES - 1) * pta_pkg::STEP_M);

  typedef enum logic [5:0] {
    S_FILL   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SEARCH = 6'b000100,
    S_MUL    = 6'b001000,
    S_DIV    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   fill_idx;
  logic [AW-1:0]                   issue_idx;
  logic                            issue_done;
  logic [AW-1:0]                   cmp_idx;
  logic                            rd_pend;

  logic [pta_pkg::PRES_W-1:0]      p;
  logic [pta_pkg::ENTRY_W-1:0]     upper;
  logic [pta_pkg::ENTRY_W-1:0]     lower;
  logic [pta_pkg::ALT_W-1:0]       res;

  logic                            ram_we;
  logic                            ram_re;
  logic [pta_pkg::ENTRY_W-1:0]     ram_rdata;
  logic                            hit;
  logic                            in_acc;
  logic                            out_load;

  logic [pta_pkg::DIV_W-1:0]       diff;
  logic [pta_pkg::NUM_W-1:0]       num;
  logic                            div_start;
  pta_pkg::div_stat_t              div_st;
  logic [pta_pkg::QUO_W-1:0]       quo;
  logic [pta_pkg::ALT_W-1:0]       alt_base;

  // Table store, loaded after reset.
  assign ram_we = (state == S_FILL);
  assign ram_re = (state == S_SEARCH) && !issue_done;

  pta_ram #(
    .WIDTH(pta_pkg::ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_idx),
    .wdata(pta_pkg::ATMOS_TABLE[pta_pkg::TBL_IW'(fill_idx)]),
    .re   (ram_re),
    .raddr(issue_idx),
    .rdata(ram_rdata)
  );

  // Handshakes.
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // The entry just read is not greater than the pressure.
  assign hit = ({1'b0, ram_rdata} <= p);

  // Rounded numerator and divisor of the interpolation.
  assign diff      = pta_pkg::DIV_W'(upper) - pta_pkg::DIV_W'(lower);
  assign num       = pta_pkg::NUM_W'(p - pta_pkg::PRES_W'(lower)) *
                     pta_pkg::NUM_W'(pta_pkg::STEP_M) +
                     pta_pkg::NUM_W'(diff >> 1);
  assign div_start = (state == S_MUL);

  pta_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(num),
    .divisor (diff),
    .stat    (div_st),
    .quotient(quo)
  );

  // Altitude of the entry where the search stopped.
  assign alt_base = pta_pkg::ALT_W'(pta_pkg::ALT_W'(cmp_idx) *
                                    pta_pkg::ALT_W'(pta_pkg::STEP_M));

  // Sequencer: fill, search one entry a cycle, divide, hand off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      fill_idx   <= '0;
      issue_idx  <= '0;
      issue_done <= 1'b0;
      cmp_idx    <= '0;
      rd_pend    <= 1'b0;
    end else begin
      unique case (state)
        S_FILL: begin
          if (fill_idx == LAST) begin
            state <= S_IDLE;
          end else begin
            fill_idx <= fill_idx + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state      <= S_SEARCH;
            issue_idx  <= '0;
            issue_done <= 1'b0;
            cmp_idx    <= '0;
            rd_pend    <= 1'b0;
          end
        end
        S_SEARCH: begin
          if (ram_re) begin
            issue_done <= (issue_idx == LAST);
            if (issue_idx != LAST) begin
              issue_idx <= issue_idx + AW'(1);
            end
          end
          rd_pend <= ram_re;
          if (rd_pend) begin
            if (hit) begin
              state <= (cmp_idx == '0) ? S_DONE : S_MUL;
            end else if (cmp_idx == LAST) begin
              state <= S_DONE;
            end else begin
              cmp_idx <= cmp_idx + AW'(1);
            end
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request payload and search results.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p <= pressure;
    end
    if ((state == S_SEARCH) && rd_pend) begin
      if (hit) begin
        lower <= ram_rdata;
        res   <= '0;
      end else begin
        upper <= ram_rdata;
        res   <= SAT_ALT;
      end
    end
    if ((state == S_DIV) && div_st.done) begin
      res <= alt_base - pta_pkg::ALT_W'(quo);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      altitude <= res;
    end
  end

  // A result never lies above the top of the table.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (altitude <= SAT_ALT))
    else $error("altitude above the table top");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

  // The table load happens once after reset and never again.
  assert property (@(posedge clk) disable iff (rst)
    (state != S_FILL) |=> (state != S_FILL))
    else $error("table load restarted");

  // After the setup step the sequencer is in the divide step with the divider busy.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_DIV) && div_st.busy)
    else $error("divider not started");

  // An accepted request always starts a search.
  assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_SEARCH))
    else $error("accepted request did not start a search");

endmodule

// ===== tb/pressure_to_altitude_interp_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pressure_to_altitude_interp_core.
// Depends on the RTL top level and on pta_pkg for the port widths.
module pressure_to_altitude_interp_core_tb;

  localparam int PRES_W = pta_pkg::PRES_W;
  localparam int ALT_W = pta_pkg::ALT_W;
  localparam int TABLE_ENTRIES = 17;
  localparam int ENTRIES_USED = (TABLE_ENTRIES > 17) ? 17 :
                                (TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES;
  localparam int STEP_METERS = 2000;
  localparam int RANDOM_ITEMS = 1026;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER = 300;
  localparam int TAIL_CYCLES = 45;
  localparam int IDLE_LIMIT = 4000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [PRES_W-1:0]  pressure;
  logic               out_valid;
  logic               out_stall;
  logic [ALT_W-1:0]   altitude;

  // Standard-atmosphere pressures, Pa/4, at 0, 2000, ... 32000 m.
  logic [15:0] pres_table [0:16] = '{
    16'd25325, 16'd19875, 16'd15415, 16'd11805,
    16'd8913,  16'd6625,  16'd4850,  16'd3543,  16'd2588,  16'd1891,
    16'd1382,  16'd1012,  16'd743,   16'd547,   16'd404,   16'd299,
    16'd222
  };

  // Directed requests; a row with known_alt set carries its answer.
  typedef struct {
    logic [PRES_W-1:0] pres;
    bit                known_alt;
    logic [ALT_W-1:0]  alt;
  } probe_row_t;

  probe_row_t probe_rows [0:23] = '{
    '{16'd0,     1'b1, 15'd32000},
    '{16'd65535, 1'b1, 15'd0},
    '{16'd32768, 1'b1, 15'd0},
    '{16'd25326, 1'b1, 15'd0},
    '{16'd25324, 1'b0, 15'd0},
    '{16'd221,   1'b1, 15'd32000},
    '{16'd223,   1'b0, 15'd0},
    '{16'd25325, 1'b1, 15'd0},
    '{16'd19875, 1'b1, 15'd2000},
    '{16'd15415, 1'b1, 15'd4000},
    '{16'd11805, 1'b1, 15'd6000},
    '{16'd8913,  1'b1, 15'd8000},
    '{16'd6625,  1'b1, 15'd10000},
    '{16'd4850,  1'b1, 15'd12000},
    '{16'd3543,  1'b1, 15'd14000},
    '{16'd2588,  1'b1, 15'd16000},
    '{16'd1891,  1'b1, 15'd18000},
    '{16'd1382,  1'b1, 15'd20000},
    '{16'd1012,  1'b1, 15'd22000},
    '{16'd743,   1'b1, 15'd24000},
    '{16'd547,   1'b1, 15'd26000},
    '{16'd404,   1'b1, 15'd28000},
    '{16'd299,   1'b1, 15'd30000},
    '{16'd222,   1'b1, 15'd32000}
  };

  logic [ALT_W-1:0] alt_expect_q [$];
  logic [ALT_W-1:0] alt_want;
  bit               req_known_alt;
  logic [ALT_W-1:0] req_alt;
  int               results_seen;
  int               mismatch_count;
  int               idle_cycles;

  pressure_to_altitude_interp_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pressure(pressure),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .altitude(altitude)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Altitude for one pressure: search the table from the ground up, then
  // interpolate between the two neighbors with a rounded divide.
  function automatic logic [ALT_W-1:0] calc_altitude(input logic [PRES_W-1:0] p);
    int unsigned idx;
    int unsigned upper;
    int unsigned lower;
    int unsigned span;
    int unsigned num;
    idx = 0;
    while (idx < ENTRIES_USED && pres_table[idx] > p) idx++;
    if (idx >= ENTRIES_USED) return ALT_W'((ENTRIES_USED - 1) * STEP_METERS);
    if (idx == 0) return '0;
    upper = pres_table[idx - 1];
    lower = pres_table[idx];
    span = upper - lower;
    if (span == 0) return ALT_W'(idx * STEP_METERS);
    num = STEP_METERS * (p - lower) + span / 2;
    return ALT_W'(idx * STEP_METERS - num / span);
  endfunction

  // Random pressure, weighted toward the interpolated range.
  function automatic logic [PRES_W-1:0] pick_pressure();
    int unsigned k;
    case ($urandom_range(0, 9))
      0: return PRES_W'($urandom);
      1: return PRES_W'($urandom_range(25325, 65535));
      2: return PRES_W'($urandom_range(0, 222));
      3: begin
        k = $urandom_range(0, 16);
        return pres_table[k] + PRES_W'($urandom_range(0, 2)) - 16'd1;
      end
      default: return PRES_W'($urandom_range(222, 25325));
    endcase
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic offer_request(input logic [PRES_W-1:0] p, input bit known,
                               input logic [ALT_W-1:0] alt);
    @(negedge clk);
    in_valid <= 1'b1;
    pressure <= p;
    req_known_alt <= known;
    req_alt <= alt;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Leave the input idle for a number of cycles, with junk on the bus.
  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      pressure <= PRES_W'($urandom);
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (alt_expect_q.size() != 0) @(posedge clk);
  endtask

  // Scoreboard: retire results, then record expectations for new requests.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (alt_expect_q.size() == 0) begin
          $display("%0t: altitude %0d with no request outstanding", $time, altitude);
          mismatch_count++;
        end else begin
          alt_want = alt_expect_q.pop_front();
          if (altitude !== alt_want) begin
            $display("%0t: altitude expected %0d, got %0d", $time, alt_want, altitude);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        alt_expect_q.push_back(req_known_alt ? req_alt : calc_altitude(pressure));
      end
    end
  end

  // Watchdog on cycles in which neither side moves anything.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("pressure_to_altitude_interp_core: mismatch");
        $finish;
      end
    end
  end

  // Result side: stall patterns that change every so often, plus one long
  // hold-off once enough results have gone by.
  initial begin
    int mode;
    int span;
    int cyc;
    bit hold_taken;
    out_stall = 1'b0;
    hold_taken = 1'b0;
    cyc = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(negedge clk);
        cyc++;
        if (!hold_taken && results_seen >= HOLD_AFTER) begin
          hold_taken = 1'b1;
          out_stall <= 1'b1;
          repeat (LONG_HOLD - 1) @(negedge clk);
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (cyc % 3 == 0);
          endcase
        end
      end
    end
  end

  // Request side: directed rows, then random bursts.
  initial begin
    int burst_left;
    rst = 1'b1;
    in_valid = 1'b0;
    pressure = '0;
    req_known_alt = 1'b0;
    req_alt = '0;
    results_seen = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i]) begin
      offer_request(probe_rows[i].pres, probe_rows[i].known_alt, probe_rows[i].alt);
      idle_sender($urandom_range(0, 3));
    end
    idle_sender(1);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
        burst_left = $urandom_range(1, 24);
      end
      offer_request(pick_pressure(), 1'b0, '0);
      burst_left--;
      // Let the block run dry once in the middle of the run.
      if (i == RANDOM_ITEMS / 2) begin
        idle_sender(1);
        wait_drained();
      end
    end

    idle_sender(1);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pressure_to_altitude_interp_core: match");
    end else begin
      $display("pressure_to_altitude_interp_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pta_pkg.sv
rtl/pta_ram.sv
rtl/pta_div.sv
rtl/pressure_to_altitude_interp_core.sv
tb/pressure_to_altitude_interp_core_tb.sv
